// ===== rtl/core/two_sat_scc_solver_macros.svh =====
// Assertion macros for the 2-SAT solver
`ifndef TWO_SAT_SCC_SOLVER_MACROS_SVH
`define TWO_SAT_SCC_SOLVER_MACROS_SVH
`ifndef SYNTHESIS
`define TSS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TSS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define TSS_ASSERT(label, clk, rst_n, prop, msg)
`define TSS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/core/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// Types and constants shared by the 2-SAT solver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tss_pkg;
	localparam int MaxVarsDef    = 64;
	localparam int MaxClausesDef = 1024;
	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_SOLVE = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [5:0] var_a;
		logic       neg_a;
		logic [5:0] var_b;
		logic       neg_b;
	} in_word_t;

	typedef struct packed {
		logic        sat;
		logic [63:0] assignment;
		logic        error;
	} out_word_t;
endpackage
`default_nettype wire

// ===== rtl/core/two_sat_scc_solver.sv =====
// ----------------------------------------------------------------------------
// two_sat_scc_solver
// A solve word runs two DFS passes; each vertex scans every stored
// clause edge by edge (read, then test) through the single
// clause-memory read port.
// One solve at a time; clauses accepted every cycle while idle.
// Reset clears counts, flags and output valid; memories need none.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "two_sat_scc_solver_macros.svh"
module two_sat_scc_solver #(
	parameter int MAX_VARS    = tss_pkg::MaxVarsDef,
	parameter int MAX_CLAUSES = tss_pkg::MaxClausesDef
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [6:0]        cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire tss_pkg::in_word_t in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output tss_pkg::out_word_t     out_data
);
	import tss_pkg::*;

	localparam int NL  = 2 * MAX_VARS;
	localparam int LW  = $clog2(NL);
	localparam int CAW = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
	localparam int CCW = $clog2(MAX_CLAUSES + 1);
	localparam int EW  = CCW + 1;
	localparam int DW  = $clog2(NL + 1);
	localparam int CPW = DW;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_FSEL  = 11'b00000000010,
		ST_FRD   = 11'b00000000100,
		ST_FEDGE = 11'b00000001000,
		ST_FVIS  = 11'b00000010000,
		ST_RINIT = 11'b00000100000,
		ST_RPOP  = 11'b00001000000,
		ST_RRD   = 11'b00010000000,
		ST_REDGE = 11'b00100000000,
		ST_RCHK  = 11'b01000000000,
		ST_EVAL  = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [6:0] num_vars_q;
	logic [CCW-1:0] ccount_q;
	logic drop_q;

	logic [13:0] cmem [MAX_CLAUSES];
	logic [13:0] crd_s1;
	logic [CAW-1:0] craddr;

	logic [LW-1:0] wv_mem [NL];
	logic [EW-1:0] wp_mem [NL];
	logic [DW-1:0] depth_q;
	logic [LW-1:0] cur_v_q;
	logic [EW-1:0] cur_p_q;

	logic [NL-1:0] vis_q;
	logic [LW-1:0] fin_mem [NL];
	logic [DW-1:0] ftop_q;
	logic [CPW-1:0] comp_mem [NL];
	logic [NL-1:0] assigned_q;
	logic [CPW-1:0] ncomp_q;
	logic [LW:0] start_q;
	logic [LW-1:0] dst_q;
	logic [LW:0] ev_q;
	logic [63:0] bits_q;
	logic sat_q;
	logic [CPW-1:0] cp_q;
	logic cp_ok_q;

	logic [6:0] n_act;
	logic [LW:0] lits;
	always_comb begin
		n_act = num_vars_q;
		if (num_vars_q == 7'd0) n_act = 7'd1;
		if ({25'd0, num_vars_q} > MAX_VARS) n_act = 7'(MAX_VARS);
	end
	assign lits = (LW+1)'({n_act, 1'b0});

	logic out_free;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || (in_data.kind == KIND_SOLVE && !out_free);

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	logic [6:0] la, lb;
	assign la = {in_data.var_a, in_data.neg_a};
	assign lb = {in_data.var_b, in_data.neg_b};
	logic add_ok;
	assign add_ok = ({1'b0, in_data.var_a} < n_act) && ({1'b0, in_data.var_b} < n_act)
		&& ({{(32-CCW){1'b0}}, ccount_q} < MAX_CLAUSES);

	// edge decode from registered clause read
	logic [6:0] ea, eb;
	logic e_ok, e_sub;
	logic [6:0] src_f, dst_f, src_r, dst_r;
	assign ea = crd_s1[6:0];
	assign eb = crd_s1[13:7];
	assign e_sub = cur_p_q[0];
	assign e_ok = ({1'b0, ea} < lits) && ({1'b0, eb} < lits);
	assign src_f = e_sub ? (eb ^ 7'd1) : (ea ^ 7'd1);
	assign dst_f = e_sub ? ea : eb;
	assign src_r = e_sub ? ea : eb;
	assign dst_r = e_sub ? (eb ^ 7'd1) : (ea ^ 7'd1);
	logic [EW-1:0] nedges;
	assign nedges = {ccount_q, 1'b0};
	logic edges_done;
	assign edges_done = cur_p_q >= nedges;

	assign craddr = (state_q == ST_IDLE) ? CAW'(ccount_q) : CAW'(cur_p_q >> 1);

	always_ff @(posedge clk) begin
		if (in_acc && in_data.kind == KIND_ADD && add_ok)
			cmem[CAW'(ccount_q)] <= {lb, la};
		crd_s1 <= cmem[craddr];
	end

	logic [LW-1:0] fin_rd_s1;
	logic [CPW-1:0] comp_rd_s1;
	logic [LW-1:0] comp_raddr;
	logic comp_we;
	logic [LW-1:0] comp_waddr;
	assign comp_raddr = (state_q == ST_EVAL) ? ev_q[LW-1:0] : LW'(dst_r);

	always_ff @(posedge clk) begin
		if (comp_we) comp_mem[comp_waddr] <= ncomp_q;
		comp_rd_s1 <= comp_mem[comp_raddr];
		fin_rd_s1  <= fin_mem[LW'(ftop_q - DW'(1))];
	end

	logic wpush, wupd;
	logic [DW-1:0] wtop;
	assign wtop = depth_q - DW'(1);
	always_ff @(posedge clk) begin
		if (wpush) begin
			wv_mem[LW'(depth_q)] <= dst_q;
			wp_mem[LW'(depth_q)] <= '0;
		end else if (wupd) begin
			wp_mem[LW'(wtop)] <= cur_p_q;
		end
	end

	logic fin_we;
	always_ff @(posedge clk) if (fin_we) fin_mem[LW'(ftop_q)] <= cur_v_q;

	logic [LW-1:0] pop_v;
	logic [EW-1:0] pop_p;
	always_ff @(posedge clk) begin
		pop_v <= wv_mem[LW'(depth_q - DW'(2))];
		pop_p <= wp_mem[LW'(depth_q - DW'(2))];
	end

	logic popping_q;

	always_comb begin
		wupd = 1'b0; fin_we = 1'b0;
		comp_we = 1'b0; comp_waddr = cur_v_q;
		unique case (state_q)
			ST_FEDGE: begin
				if (edges_done) fin_we = ({{(32-DW){1'b0}}, ftop_q} < NL);
			end
			ST_FVIS: begin
				if (!vis_q[dst_q] && {{(32-DW){1'b0}}, depth_q} < NL) begin
					wupd = 1'b1;
				end
			end
			ST_RCHK: begin
				if (!assigned_q[dst_q] && {{(32-DW){1'b0}}, depth_q} < NL) begin
					wupd = 1'b1; comp_we = 1'b1; comp_waddr = dst_q;
				end
			end
			ST_RPOP: begin
				comp_we = !popping_q && !assigned_q[fin_rd_s1];
				comp_waddr = fin_rd_s1;
			end
			default: ;
		endcase
	end

	// push happens in the cycle after wupd (write top pos then push child)
	logic push_q;
	assign wpush = push_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; num_vars_q <= 7'd1; ccount_q <= '0; drop_q <= 1'b0;
			out_valid <= 1'b0; depth_q <= '0; ftop_q <= '0; vis_q <= '0;
			assigned_q <= '0; ncomp_q <= '0; start_q <= '0; push_q <= 1'b0;
			popping_q <= 1'b0; ev_q <= '0; sat_q <= 1'b0; bits_q <= '0;
			cur_v_q <= '0; cur_p_q <= '0; dst_q <= '0; cp_q <= '0; cp_ok_q <= 1'b0;
		end else begin
			push_q <= 1'b0;
			if (cfg_we) num_vars_q <= cfg_wdata;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_data.kind == KIND_ADD) begin
							if (add_ok) ccount_q <= ccount_q + CCW'(1);
							else drop_q <= 1'b1;
						end else begin
							vis_q <= '0; ftop_q <= '0; start_q <= '0;
							state_q <= ST_FSEL;
						end
					end
				end
				ST_FSEL: begin
					if (start_q >= lits) state_q <= ST_RINIT;
					else if (vis_q[start_q[LW-1:0]]) start_q <= start_q + 1'b1;
					else begin
						vis_q[start_q[LW-1:0]] <= 1'b1;
						dst_q <= start_q[LW-1:0];
						depth_q <= '0;
						push_q <= 1'b1;
						cur_v_q <= start_q[LW-1:0]; cur_p_q <= '0;
						start_q <= start_q + 1'b1;
						state_q <= ST_FRD;
					end
				end
				ST_FRD: begin
					if (push_q) depth_q <= depth_q + DW'(1);
					state_q <= ST_FEDGE;
				end
				ST_FEDGE: begin
					if (edges_done) begin
						if (fin_we) ftop_q <= ftop_q + DW'(1);
						depth_q <= depth_q - DW'(1);
						if (depth_q == DW'(1)) state_q <= ST_FSEL;
						else begin
							cur_v_q <= pop_v; cur_p_q <= pop_p;
							state_q <= ST_FRD;
						end
					end else begin
						cur_p_q <= cur_p_q + EW'(1);
						if (e_ok && src_f[LW-1:0] == cur_v_q) begin
							dst_q <= dst_f[LW-1:0];
							state_q <= ST_FVIS;
						end else state_q <= ST_FRD;
					end
				end
				ST_FVIS: begin
					if (wupd) begin
						vis_q[dst_q] <= 1'b1;
						push_q <= 1'b1;
						cur_v_q <= dst_q; cur_p_q <= '0;
					end
					state_q <= ST_FRD;
				end
				ST_RINIT: begin
					assigned_q <= '0; ncomp_q <= '0; popping_q <= 1'b1;
					state_q <= ST_RPOP;
				end
				ST_RPOP: begin
					if (popping_q) begin
						if (ftop_q == '0) begin
							ev_q <= '0; sat_q <= 1'b1; bits_q <= '0; cp_ok_q <= 1'b0;
							state_q <= ST_EVAL;
						end else popping_q <= 1'b0;
					end else begin
						ftop_q <= ftop_q - DW'(1);
						popping_q <= 1'b1;
						if (!assigned_q[fin_rd_s1]) begin
							assigned_q[fin_rd_s1] <= 1'b1;
							dst_q <= fin_rd_s1; depth_q <= '0; push_q <= 1'b1;
							cur_v_q <= fin_rd_s1; cur_p_q <= '0;
							state_q <= ST_RRD;
						end
					end
				end
				ST_RRD: begin
					if (push_q) depth_q <= depth_q + DW'(1);
					state_q <= ST_REDGE;
				end
				ST_REDGE: begin
					if (edges_done) begin
						depth_q <= depth_q - DW'(1);
						if (depth_q == DW'(1)) begin
							ncomp_q <= ncomp_q + CPW'(1);
							state_q <= ST_RPOP;
						end else begin
							cur_v_q <= pop_v; cur_p_q <= pop_p;
							state_q <= ST_RRD;
						end
					end else begin
						cur_p_q <= cur_p_q + EW'(1);
						if (e_ok && src_r[LW-1:0] == cur_v_q) begin
							dst_q <= dst_r[LW-1:0];
							state_q <= ST_RCHK;
						end else state_q <= ST_RRD;
					end
				end
				ST_RCHK: begin
					if (wupd) begin
						assigned_q[dst_q] <= 1'b1;
						push_q <= 1'b1;
						cur_v_q <= dst_q; cur_p_q <= '0;
					end
					state_q <= ST_RRD;
				end
				ST_EVAL: begin
					// ev_q issues reads; pairs are compared in the cycle after
					if (cp_ok_q) begin
						if (ev_q[0]) cp_q <= comp_rd_s1;
						else begin
							if (cp_q == comp_rd_s1) sat_q <= 1'b0;
							if (cp_q < comp_rd_s1) bits_q[6'((ev_q - 1'b1) >> 1)] <= 1'b1;
						end
					end
					if (ev_q > lits) begin
						out_valid <= 1'b1;
						ccount_q <= '0; drop_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						ev_q <= ev_q + 1'b1;
						cp_ok_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL && ev_q > lits) begin
			out_data.sat <= sat_q;
			out_data.assignment <= sat_q ? bits_q : 64'd0;
			out_data.error <= drop_q;
		end
	end

	`TSS_ASSERT(a_onehot, clk, arst_n, $onehot(state_q), "state not one-hot")
	`TSS_ASSERT(a_busy_stall, clk, arst_n, (state_q == ST_IDLE) || in_stall, "input taken while busy")
	`TSS_ASSERT_NEXT(a_clear, clk, arst_n, state_q == ST_EVAL && ev_q > lits, ccount_q == '0 && out_valid, "store not cleared")
	`TSS_ASSERT(a_depth, clk, arst_n, {{(32-DW){1'b0}}, depth_q} <= NL, "walk stack overflow")
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks two_sat_scc_solver against an in-bench SCC predictor. Clause and
// solve words go in with random gaps, result words come out under random
// stall, and every result is compared field by field with the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import tss_pkg::*;

	localparam int NumLits    = 2 * MaxVarsDef;
	localparam int NoComp     = 'hFFFF;
	localparam int IdleLimit  = 400000;
	localparam int TargetWords = 1800;

	class sat_scoreboard;
		logic [13:0] clauses[MaxClausesDef];
		int          n_clauses;
		bit          dropped;
		int          num_vars;
		bit          seen[NumLits];
		int          finish_order[NumLits];
		int          finish_top;
		int          walk_v[NumLits];
		int          walk_pos[NumLits];
		int          walk_depth;
		int          comp_of[NumLits];
		out_word_t   pending[$];
		int          errors;

		function new();
			n_clauses = 0;
			dropped = 0;
			num_vars = 1;
			errors = 0;
		endfunction

		function int active_vars();
			if (num_vars < 1) return 1;
			if (num_vars > MaxVarsDef) return MaxVarsDef;
			return num_vars;
		endfunction

		// next neighbour of v from the edge cursor of stack slot t, -1 if none
		function int next_neighbour(int v, int t, bit rev, int lits);
			int k, a, b, src, dst;
			bit sub;
			while (walk_pos[t] < 2 * n_clauses) begin
				k = walk_pos[t] >> 1;
				sub = walk_pos[t][0];
				walk_pos[t]++;
				a = clauses[k][6:0];
				b = clauses[k][13:7];
				if (a >= lits || b >= lits) continue;
				if (!rev) begin
					src = sub ? (b ^ 1) : (a ^ 1);
					dst = sub ? a : b;
				end else begin
					src = sub ? a : b;
					dst = sub ? (b ^ 1) : (a ^ 1);
				end
				if (src == v) return dst;
			end
			return -1;
		endfunction

		function void walk(int start, bit rev, int comp, int lits);
			int t, v, u;
			if (rev) comp_of[start] = comp;
			else seen[start] = 1;
			walk_depth = 1;
			walk_v[0] = start;
			walk_pos[0] = 0;
			while (walk_depth > 0) begin
				t = walk_depth - 1;
				v = walk_v[t];
				u = next_neighbour(v, t, rev, lits);
				if (u < 0) begin
					if (!rev && finish_top < NumLits) begin
						finish_order[finish_top] = v;
						finish_top++;
					end
					walk_depth--;
				end else if (walk_depth < NumLits &&
						(rev ? comp_of[u] == NoComp : !seen[u])) begin
					if (rev) comp_of[u] = comp;
					else seen[u] = 1;
					walk_v[walk_depth] = u;
					walk_pos[walk_depth] = 0;
					walk_depth++;
				end
			end
		endfunction

		function void note_word(in_word_t w);
			int n, lits, v, comp;
			out_word_t r;
			n = active_vars();
			lits = 2 * n;
			if (w.kind == KIND_ADD) begin
				if (w.var_a >= n || w.var_b >= n || n_clauses >= MaxClausesDef) begin
					dropped = 1;
				end else begin
					clauses[n_clauses] = {w.var_b, w.neg_b, w.var_a, w.neg_a};
					n_clauses++;
				end
				return;
			end
			foreach (seen[i]) seen[i] = 0;
			finish_top = 0;
			for (int s = 0; s < lits; s++)
				if (!seen[s]) walk(s, 0, 0, lits);
			foreach (comp_of[i]) comp_of[i] = NoComp;
			comp = 0;
			while (finish_top > 0) begin
				finish_top--;
				v = finish_order[finish_top];
				if (comp_of[v] == NoComp) begin
					walk(v, 1, comp, lits);
					comp++;
				end
			end
			r.sat = 1;
			r.assignment = '0;
			for (int i = 0; i < n; i++) begin
				if (comp_of[2*i] == comp_of[2*i+1]) begin
					r.sat = 0;
					break;
				end
				if (comp_of[2*i] < comp_of[2*i+1]) r.assignment[i] = 1'b1;
			end
			if (!r.sat) r.assignment = '0;
			r.error = dropped;
			pending.insert(pending.size(), r);
			n_clauses = 0;
			dropped = 0;
		endfunction

		function void check_result(out_word_t got);
			out_word_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result word %h", got);
				return;
			end
			want = pending.pop_front();
			if (got.sat !== want.sat || got.assignment !== want.assignment ||
					got.error !== want.error) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp sat=%0d asg=%h err=%0d, got sat=%0d asg=%h err=%0d",
						want.sat, want.assignment, want.error,
						got.sat, got.assignment, got.error);
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic [6:0] cfg_wdata;
	logic      in_valid;
	logic      in_stall;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_word_t out_data;

	sat_scoreboard sb;
	bit  hold_req;
	int  idle_cycles;
	int  words_sent;

	two_sat_scc_solver uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic in_word_t clause_word(int va, bit na, int vb, bit nb);
		in_word_t w;
		w.kind = KIND_ADD;
		w.var_a = 6'(va);
		w.neg_a = na;
		w.var_b = 6'(vb);
		w.neg_b = nb;
		return w;
	endfunction

	function automatic in_word_t solve_word();
		in_word_t w;
		w = in_word_t'(15'($urandom));
		w.kind = KIND_SOLVE;
		return w;
	endfunction

	task automatic send_word(in_word_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			in_data <= in_word_t'(15'($urandom));
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
		sb.note_word(w);
		words_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_vars(int v);
		cfg_we <= 1'b1;
		cfg_wdata <= 7'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.num_vars = v;
	endtask

	function automatic int pick_var(int n);
		if ($urandom_range(0, 99) < 6) return $urandom_range(0, 63);
		return $urandom_range(0, n - 1);
	endfunction

	task automatic send_problem(int n, int max_k);
		int k;
		k = $urandom_range(0, max_k);
		repeat (k)
			send_word(clause_word(pick_var(n), 1'($urandom), pick_var(n), 1'($urandom)));
		send_word(solve_word());
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) sb.check_result(out_data);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		int r;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (600) @(posedge clk);
			end
			r = $urandom_range(0, 99);
			if (r < 30) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(20, 200)) @(posedge clk);
			end else begin
				out_stall <= (r < 60);
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	initial begin
		int n, r;
		sb = new();
		hold_req = 1'b0;
		idle_cycles = 0;
		words_sent = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full width, extreme variables, empty solve
		set_vars(64);
		send_word(solve_word());
		send_word(clause_word(63, 1, 0, 0));
		send_word(clause_word(63, 0, 63, 0));
		send_word(clause_word(0, 1, 62, 1));
		send_word(solve_word());
		// contradiction on one variable
		send_word(clause_word(5, 0, 5, 0));
		send_word(clause_word(5, 1, 5, 1));
		send_word(solve_word());
		drain();
		// out-of-range variable, then flag cleared
		set_vars(4);
		send_word(clause_word(1, 0, 2, 1));
		send_word(clause_word(63, 0, 1, 0));
		send_word(clause_word(0, 1, 4, 1));
		send_word(solve_word());
		send_word(solve_word());
		// clauses loaded at 8 variables, solved at 2
		drain();
		set_vars(8);
		send_word(clause_word(7, 0, 7, 0));
		send_word(clause_word(0, 1, 1, 0));
		send_word(clause_word(1, 1, 0, 0));
		drain();
		set_vars(2);
		send_word(solve_word());
		drain();
		// register values outside range
		set_vars(0);
		send_word(clause_word(0, 0, 0, 1));
		send_word(clause_word(1, 0, 0, 0));
		send_word(solve_word());
		drain();
		set_vars(127);
		send_word(clause_word(63, 1, 63, 1));
		send_word(solve_word());
		drain();
		// store overflow
		set_vars(1);
		for (int i = 0; i <= MaxClausesDef; i++)
			send_word(clause_word(0, i[0], 0, i[1]));
		send_word(solve_word());
		drain();

		// receiver holds off while solves keep coming
		set_vars(3);
		hold_req = 1'b1;
		repeat (8) send_problem(3, 4);
		drain();

		while (words_sent < TargetWords) begin
			r = $urandom_range(0, 99);
			if (r < 60) n = $urandom_range(1, 8);
			else if (r < 80) n = $urandom_range(9, 24);
			else if (r < 90) n = 64;
			else if (r < 95) n = 0;
			else n = $urandom_range(65, 127);
			set_vars(n);
			n = sb.active_vars();
			repeat ($urandom_range(2, 8)) begin
				r = $urandom_range(0, 99);
				if (r < 85) send_problem(n, (n > 24) ? 30 : 14);
				else if (r < 93) send_word(solve_word());
				else send_word(clause_word(pick_var(n), 1'($urandom), pick_var(n),
					1'($urandom)));
			end
			send_word(solve_word());
			drain();
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
